// ===== rtl/reciprocal_frequency_meter_macros.svh =====
// assertion macros shared by the reciprocal frequency meter modules
`ifndef RECIPROCAL_FREQUENCY_METER_MACROS_SVH
`define RECIPROCAL_FREQUENCY_METER_MACROS_SVH

// same-cycle implication
`define RFM_ASSERT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RFM_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rfm_pkg.sv =====
// shared constants and types of the reciprocal frequency meter
package rfm_pkg;

  localparam int CAP_W         = 32;
  localparam int COUNTER_WIDTH = 32;
  localparam int FRACTION_BITS = 16;
  localparam int RATE_W        = 28;
  localparam int PERIOD_W      = 32;
  localparam int FREQ_W        = 44;

  localparam int NUM_W  = RATE_W + FRACTION_BITS;
  localparam int QW     = (NUM_W > FREQ_W) ? NUM_W : FREQ_W;
  localparam int STEP_W = $clog2(NUM_W);

  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(NUM_W - 1);
  localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000000);

  localparam int QD     = 2;
  localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCNT_W = $clog2(QD + 1);

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic                nonzero;
  } job_t;

endpackage

// ===== rtl/rfm_capture_if.sv =====
// capture item channel
interface rfm_capture_if;
  logic                       valid;
  logic                       ready;
  logic [rfm_pkg::CAP_W-1:0]  capture_value;

  modport source (output valid, output capture_value, input ready);
  modport sink (input valid, input capture_value, output ready);
endinterface

// ===== rtl/rfm_result_if.sv =====
// result item channel
interface rfm_result_if;
  logic                          valid;
  logic                          ready;
  logic [rfm_pkg::PERIOD_W-1:0]  period_ticks;
  logic [rfm_pkg::FREQ_W-1:0]    frequency_q16;
  logic                          frequency_valid;

  modport source (output valid, output period_ticks, output frequency_q16,
                  output frequency_valid, input ready);
  modport sink (input valid, input period_ticks, input frequency_q16,
                input frequency_valid, output ready);
endinterface

// ===== rtl/reciprocal_frequency_meter.sv =====
// reciprocal frequency meter top level
// Takes one timer capture per item and returns its period, the latest
// frequency in unsigned Q.16 hertz and a sticky valid flag. The first capture
// after reset and a repeated capture skip the divide and take the held
// frequency; any other capture runs a radix-2 restoring divide of
// tick_rate_hz shifted by the fraction bits over the period, one quotient bit
// per cycle, in the back end. A two-entry queue behind the front end keeps
// taking captures while a divide runs or a result waits. Write tick_rate_hz
// only while the meter is idle.
module reciprocal_frequency_meter (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rfm_pkg::RATE_W-1:0] cfg_wdata,
  rfm_capture_if.sink                capture,
  rfm_result_if.source               result
);

  logic [rfm_pkg::RATE_W-1:0] tick_rate;
  rfm_pkg::job_t              front_job;
  logic                       front_valid;
  logic                       front_ready;
  rfm_pkg::job_t              back_job;
  logic                       back_valid;
  logic                       back_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= rfm_pkg::RATE_RESET;
    end else if (cfg_we) begin
      tick_rate <= cfg_wdata;
    end
  end

  rfm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .capture   (capture),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  rfm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  rfm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tick_rate (tick_rate),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .result    (result)
  );

endmodule

// ===== rtl/rfm_front.sv =====
// capture front end: period from the previous capture
module rfm_front (
  input  logic          clk,
  input  logic          rst,
  rfm_capture_if.sink   capture,
  output rfm_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_ready
);

  logic                              have_previous;
  logic [rfm_pkg::COUNTER_WIDTH-1:0] previous_capture;
  logic [rfm_pkg::COUNTER_WIDTH-1:0] cap_low;
  logic [rfm_pkg::COUNTER_WIDTH-1:0] diff;

  assign cap_low       = capture.capture_value[rfm_pkg::COUNTER_WIDTH-1:0];
  assign diff          = cap_low - previous_capture;
  assign capture.ready = job_ready;
  assign job_valid     = capture.valid;

  always_comb begin
    job.period  = have_previous ? rfm_pkg::PERIOD_W'(diff) : '0;
    job.nonzero = have_previous && (diff != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous    <= 1'b0;
      previous_capture <= '0;
    end else if (capture.valid && job_ready) begin
      have_previous    <= 1'b1;
      previous_capture <= cap_low;
    end
  end

endmodule

// ===== rtl/rfm_queue.sv =====
// short job queue between front end and divider
`include "reciprocal_frequency_meter_macros.svh"

module rfm_queue (
  input  logic          clk,
  input  logic          rst,
  input  rfm_pkg::job_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output rfm_pkg::job_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);

  rfm_pkg::job_t                mem [rfm_pkg::QD];
  logic [rfm_pkg::QPTR_W-1:0]   wptr;
  logic [rfm_pkg::QPTR_W-1:0]   rptr;
  logic [rfm_pkg::QCNT_W-1:0]   count;
  logic                         push;
  logic                         pop;

  assign push_ready = (count != rfm_pkg::QCNT_W'(rfm_pkg::QD));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == rfm_pkg::QPTR_W'(rfm_pkg::QD - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == rfm_pkg::QPTR_W'(rfm_pkg::QD - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `RFM_ASSERT(a_count_bound, clk, rst, 1'b1, count <= rfm_pkg::QCNT_W'(rfm_pkg::QD), "queue count over depth")
  `RFM_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "queue count did not rise")
  `RFM_ASSERT_NEXT(a_count_down, clk, rst, pop && !push, count == $past(count) - 1'b1, "queue count did not fall")

endmodule

// ===== rtl/rfm_back.sv =====
// back end: radix-2 divider, held frequency and result register
`include "reciprocal_frequency_meter_macros.svh"

module rfm_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [rfm_pkg::RATE_W-1:0] tick_rate,
  input  rfm_pkg::job_t              job,
  input  logic                       job_valid,
  output logic                       job_ready,
  rfm_result_if.source               result
);

  typedef enum logic {S_IDLE, S_DIV} state_t;

  state_t                              state;
  logic [rfm_pkg::NUM_W-1:0]           num;
  logic [rfm_pkg::COUNTER_WIDTH-1:0]   rem;
  logic [rfm_pkg::COUNTER_WIDTH-1:0]   divisor;
  logic [rfm_pkg::PERIOD_W-1:0]        period_hold;
  logic [rfm_pkg::STEP_W-1:0]          step_cnt;
  logic [rfm_pkg::FREQ_W-1:0]          frequency_reg;
  logic                                valid_reg;

  logic                                out_valid;
  logic [rfm_pkg::PERIOD_W-1:0]        out_period;
  logic [rfm_pkg::FREQ_W-1:0]          out_freq;
  logic                                out_fvalid;

  logic [rfm_pkg::COUNTER_WIDTH:0]     rem_shift;
  logic [rfm_pkg::COUNTER_WIDTH:0]     diff;
  logic                                fits;
  logic [rfm_pkg::COUNTER_WIDTH-1:0]   rem_next;
  logic [rfm_pkg::NUM_W-1:0]           num_next;
  logic [rfm_pkg::QW-1:0]              quot_ext;
  logic [rfm_pkg::FREQ_W-1:0]          freq_new;
  logic                                out_free;
  logic                                take;

  assign out_free  = !out_valid || result.ready;
  assign job_ready = (state == S_IDLE) && out_free;
  assign take      = job_valid && job_ready;

  // one restoring step, quotient bits shift into num
  always_comb begin
    rem_shift = {rem, num[rfm_pkg::NUM_W-1]};
    diff      = rem_shift - {1'b0, divisor};
    fits      = !diff[rfm_pkg::COUNTER_WIDTH];
    rem_next  = fits ? diff[rfm_pkg::COUNTER_WIDTH-1:0]
                     : rem_shift[rfm_pkg::COUNTER_WIDTH-1:0];
    num_next  = {num[rfm_pkg::NUM_W-2:0], fits};
    quot_ext  = rfm_pkg::QW'(num_next);
    freq_new  = (quot_ext > rfm_pkg::QW'(rfm_pkg::FREQ_MAX)) ? rfm_pkg::FREQ_MAX
                                                            : quot_ext[rfm_pkg::FREQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      frequency_reg <= '0;
      valid_reg     <= 1'b0;
      step_cnt      <= '0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (job.nonzero) begin
              num         <= rfm_pkg::NUM_W'(tick_rate) << rfm_pkg::FRACTION_BITS;
              rem         <= '0;
              divisor     <= job.period[rfm_pkg::COUNTER_WIDTH-1:0];
              period_hold <= job.period;
              step_cnt    <= '0;
              state       <= S_DIV;
            end else begin
              out_period <= job.period;
              out_freq   <= frequency_reg;
              out_fvalid <= valid_reg;
              out_valid  <= 1'b1;
            end
          end
        end
        S_DIV: begin
          num      <= num_next;
          rem      <= rem_next;
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == rfm_pkg::LAST_STEP) begin
            frequency_reg <= freq_new;
            valid_reg     <= 1'b1;
            out_period    <= period_hold;
            out_freq      <= freq_new;
            out_fvalid    <= 1'b1;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid           = out_valid;
  assign result.period_ticks    = out_period;
  assign result.frequency_q16   = out_freq;
  assign result.frequency_valid = out_fvalid;

  `RFM_ASSERT(a_out_free_in_div, clk, rst, state == S_DIV, !out_valid, "result register busy during divide")
  `RFM_ASSERT_NEXT(a_valid_sticky, clk, rst, valid_reg, valid_reg, "frequency valid flag dropped")
  `RFM_ASSERT_NEXT(a_div_done, clk, rst, (state == S_DIV) && (step_cnt == rfm_pkg::LAST_STEP), out_valid && out_fvalid && (state == S_IDLE), "divide end gave no valid result")

endmodule
